// File: hdl/closest_points_between_segments_core_macros.svh
// Assertion macros used by the top file of the segment core, the only file that asserts.
`ifndef CLOSEST_POINTS_BETWEEN_SEGMENTS_CORE_MACROS_SVH
`define CLOSEST_POINTS_BETWEEN_SEGMENTS_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check a condition at every clock edge outside reset.
`define CPSC_ASSERT(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("segment core assertion failed");
// Check that an antecedent implies a consequent in the next cycle.
`define CPSC_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("segment core assertion failed");
`else
`define CPSC_ASSERT(name, clk, rst, cond)
`define CPSC_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// File: hdl/cpsc_pkg.sv
package cpsc_pkg;

  localparam int CRD_W     = 32;            // Q16.16 coordinate
  localparam int DIF_W     = CRD_W + 1;     // coordinate difference
  localparam int PRD_W     = 2 * DIF_W;     // product of two differences
  localparam int DOT_W     = PRD_W + 2;     // sum of three products
  localparam int LIMB_W    = DOT_W / 2;     // multiplier limb
  localparam int MAG_W     = 2 * DOT_W;     // product of two dot magnitudes
  localparam int WIDE_W    = MAG_W + 4;     // signed wide word
  localparam int TOL_W     = 24;            // tolerance, Q0.24
  localparam int TPP_W     = TOL_W + LIMB_W;
  localparam int TPP_N     = 4;             // limbs of a*e seen by the tolerance
  localparam int CMP_W     = WIDE_W + TOL_W;
  localparam int DIV_W     = WIDE_W;
  localparam int FAC_FRAC  = 16;
  localparam int FAC_W     = FAC_FRAC + 1;  // Q0.16 with room for 1.0
  localparam int DIV_STEPS = FAC_W;
  localparam int DIV_LAT   = DIV_STEPS + 2;
  localparam int BPP_W     = LIMB_W + FAC_W;
  localparam int PIP_W     = DIF_W + FAC_W + 1;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic [FAC_W-1:0] FAC_ONE   = FAC_W'(1 << FAC_FRAC);
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(2);

  typedef logic [2:0][CRD_W-1:0] vec_crd_t;
  typedef logic [2:0][DIF_W-1:0] vec_dif_t;

  typedef struct packed {
    vec_crd_t p1;
    vec_dif_t d1;
    vec_crd_t p2;
    vec_dif_t d2;
  } geo_t;

  typedef struct packed {
    logic [DOT_W-1:0] a;
    logic [DOT_W-1:0] b;
    logic [DOT_W-1:0] c;
    logic [DOT_W-1:0] e;
    logic [DOT_W-1:0] f;
    logic             pt1;
    logic             pt2;
  } dots_t;

  typedef struct packed {
    geo_t  geo;
    dots_t dots;
  } fe_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [1:0] {
    SSEL_ZERO,
    SSEL_FIRST,
    SSEL_DIV
  } ssel_t;

  // Sign-extend a coordinate to difference width.
  function automatic logic signed [DIF_W-1:0] sx(input logic [CRD_W-1:0] v);
    return {v[CRD_W-1], v};
  endfunction

endpackage

// File: hdl/cpsc_front.sv
module cpsc_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [11:0][cpsc_pkg::CRD_W-1:0]      raw_in,
  output logic                                  push,
  input  logic                                  q_ready,
  output cpsc_pkg::fe_t                         push_item
);
  import cpsc_pkg::*;

  logic [3:0]                  fv;
  logic                        adv;
  logic [11:0][CRD_W-1:0]      raw;
  geo_t                        g1;
  vec_dif_t                    r1;
  geo_t                        g2;
  logic [4:0][2:0][PRD_W-1:0]  pr2;
  fe_t                         f3;
  logic [4:0][DOT_W-1:0]       sums;

  // Advance when the last stage is empty or the queue takes its item
  assign adv       = !fv[3] || q_ready;
  assign in_ready  = adv;
  assign push      = fv[3] && q_ready;
  assign push_item = f3;

  // Add up the three products of each dot
  always_comb begin
    for (int k = 0; k < 5; k++) begin
      sums[k] = DOT_W'($signed(pr2[k][0])) + DOT_W'($signed(pr2[k][1]))
              + DOT_W'($signed(pr2[k][2]));
    end
  end

  // Hold stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else if (adv) begin
      fv <= {fv[2:0], in_valid};
    end
  end

  // Advance the payload: register, differences, products, dots
  always_ff @(posedge clk) begin
    if (adv) begin
      raw <= raw_in;
      for (int i = 0; i < 3; i++) begin
        g1.p1[i] <= raw[i];
        g1.p2[i] <= raw[6 + i];
        g1.d1[i] <= sx(raw[3 + i]) - sx(raw[i]);
        g1.d2[i] <= sx(raw[9 + i]) - sx(raw[6 + i]);
        r1[i]    <= sx(raw[i]) - sx(raw[6 + i]);
      end
      g2 <= g1;
      for (int i = 0; i < 3; i++) begin
        pr2[0][i] <= $signed(g1.d1[i]) * $signed(g1.d1[i]);
        pr2[1][i] <= $signed(g1.d2[i]) * $signed(g1.d2[i]);
        pr2[2][i] <= $signed(g1.d1[i]) * $signed(g1.d2[i]);
        pr2[3][i] <= $signed(g1.d1[i]) * $signed(r1[i]);
        pr2[4][i] <= $signed(g1.d2[i]) * $signed(r1[i]);
      end
      f3.geo      <= g2;
      f3.dots.a   <= sums[0];
      f3.dots.e   <= sums[1];
      f3.dots.b   <= sums[2];
      f3.dots.c   <= sums[3];
      f3.dots.f   <= sums[4];
      f3.dots.pt1 <= (sums[0] == '0);
      f3.dots.pt2 <= (sums[1] == '0);
    end
  end

endmodule

// File: hdl/cpsc_fifo.sv
module cpsc_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  cpsc_pkg::fe_t        push_item,
  output logic                 q_ready,
  input  logic                 pop,
  output logic                 q_valid,
  output cpsc_pkg::fe_t        pop_item,
  output cpsc_pkg::fifo_stat_t stat
);
  import cpsc_pkg::*;

  fe_t                mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp;
  logic [FIFO_AW-1:0] rp;
  logic [FIFO_AW:0]   cnt;

  assign q_ready    = (cnt != (FIFO_AW + 1)'(FIFO_DEPTH));
  assign q_valid    = (cnt != '0);
  assign pop_item   = mem[rp];
  assign stat.full  = !q_ready;
  assign stat.empty = !q_valid;

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// File: hdl/cpsc_wmul.sv
module cpsc_wmul (
  input  logic                                clk,
  input  logic                                en,
  input  logic [cpsc_pkg::DOT_W-1:0]          x,
  input  logic [cpsc_pkg::DOT_W-1:0]          y,
  output logic [cpsc_pkg::WIDE_W-1:0]         p
);
  import cpsc_pkg::*;

  logic [DOT_W-1:0]   mx;
  logic [DOT_W-1:0]   my;
  logic [2*LIMB_W-1:0] pp00, pp01, pp10, pp11;
  logic               sg;
  logic [MAG_W-1:0]   sum;
  logic [WIDE_W-1:0]  ext;

  // Take magnitudes of the signed operands
  assign mx = x[DOT_W-1] ? DOT_W'(-x) : x;
  assign my = y[DOT_W-1] ? DOT_W'(-y) : y;

  // Combine limb products
  assign sum = (MAG_W'(pp11) << (2 * LIMB_W)) + (MAG_W'(pp01) << LIMB_W)
             + (MAG_W'(pp10) << LIMB_W) + MAG_W'(pp00);
  assign ext = WIDE_W'(sum);

  // Form limb products, then restore the sign
  always_ff @(posedge clk) begin
    if (en) begin
      pp00 <= mx[LIMB_W-1:0] * my[LIMB_W-1:0];
      pp01 <= mx[LIMB_W-1:0] * my[DOT_W-1:LIMB_W];
      pp10 <= mx[DOT_W-1:LIMB_W] * my[LIMB_W-1:0];
      pp11 <= mx[DOT_W-1:LIMB_W] * my[DOT_W-1:LIMB_W];
      sg   <= x[DOT_W-1] ^ y[DOT_W-1];
      p    <= sg ? -ext : ext;
    end
  end

endmodule

// File: hdl/cpsc_div.sv
module cpsc_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [cpsc_pkg::DIV_W-1:0]    num,
  input  logic [cpsc_pkg::DIV_W-1:0]    den,
  output logic [cpsc_pkg::FAC_W-1:0]    q
);
  import cpsc_pkg::*;

  logic [DIV_W-1:0] rem_q  [DIV_STEPS+1];
  logic [DIV_W-1:0] den_q  [DIV_STEPS+1];
  logic [FAC_W-1:0] quo_q  [DIV_STEPS+1];
  logic             zero_q [DIV_STEPS+1];
  logic             one_q  [DIV_STEPS+1];
  logic [FAC_W:0]   rnd;

  // Classify: not positive gives 0, at or above the divisor gives 1.0
  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0]  <= num;
      den_q[0]  <= den;
      quo_q[0]  <= '0;
      zero_q[0] <= num[DIV_W-1] || (num == '0);
      one_q[0]  <= ($signed(num) >= $signed(den));
    end
  end

  // One restoring quotient bit per stage
  for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_step
    logic [DIV_W:0] sh;
    logic           ge;
    assign sh = {rem_q[i-1], 1'b0};
    assign ge = (sh >= {1'b0, den_q[i-1]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i]  <= ge ? DIV_W'(sh - {1'b0, den_q[i-1]}) : DIV_W'(sh);
        den_q[i]  <= den_q[i-1];
        quo_q[i]  <= {quo_q[i-1][FAC_W-2:0], ge};
        zero_q[i] <= zero_q[i-1];
        one_q[i]  <= one_q[i-1];
      end
    end
  end

  // Round half up and apply the clamps
  assign rnd = {1'b0, quo_q[DIV_STEPS]} + (FAC_W + 1)'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_q[DIV_STEPS]) begin
        q <= '0;
      end else if (one_q[DIV_STEPS]) begin
        q <= FAC_ONE;
      end else begin
        q <= rnd[FAC_W:1];
      end
    end
  end

endmodule

// File: hdl/cpsc_back.sv
module cpsc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [cpsc_pkg::TOL_W-1:0]    tol,
  input  logic                          q_valid,
  output logic                          pop,
  input  cpsc_pkg::fe_t                 pop_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cpsc_pkg::vec_crd_t            near1,
  output cpsc_pkg::vec_crd_t            near2,
  output logic [cpsc_pkg::FAC_W-1:0]    sfac,
  output logic [cpsc_pkg::FAC_W-1:0]    tfac
);
  import cpsc_pkg::*;

  localparam int ST_DET = 3;
  localparam int ST_RHS = ST_DET + 1;
  localparam int ST_PAR = ST_RHS + 1;
  localparam int ST_D1  = ST_PAR + DIV_LAT;
  localparam int ST_BPP = ST_D1 + 1;
  localparam int ST_TN  = ST_BPP + 1;
  localparam int ST_SEL = ST_TN + 1;
  localparam int ST_D2  = ST_SEL + DIV_LAT;
  localparam int ST_IP  = ST_D2 + 1;
  localparam int ST_OUT = ST_IP + 1;
  localparam int NST    = ST_OUT + 1;

  typedef struct packed {
    geo_t                       geo;
    dots_t                      dots;
    logic [WIDE_W-1:0]          det;
    logic [WIDE_W-1:0]          num1;
    logic [TPP_N-1:0][TPP_W-1:0] tpp;
    logic [CMP_W-1:0]           rhs;
    logic                       force1;
    logic [FAC_W-1:0]           s1;
    logic                       bsg;
    logic [1:0][BPP_W-1:0]      bpp;
    logic [WIDE_W-1:0]          tnum;
    logic [WIDE_W-1:0]          tden;
    logic [WIDE_W-1:0]          snum;
    ssel_t                      ssel;
    logic                       tzero;
    logic [FAC_W-1:0]           sf;
    logic [FAC_W-1:0]           tf;
    logic [5:0][PIP_W-1:0]      ip;
    vec_crd_t                   n1;
    vec_crd_t                   n2;
  } bk_t;

  logic [NST-1:0]    v;
  logic              adv;
  bk_t               sd [NST];
  bk_t               nx [NST];
  logic [WIDE_W-1:0] ae, bb, bf, ce;
  logic [FAC_W-1:0]  q1, q2, q3;

  // Advance when the output is empty or being taken
  assign adv       = !v[NST-1] || out_ready;
  assign pop       = adv && q_valid;
  assign out_valid = v[NST-1];
  assign near1     = sd[ST_OUT].n1;
  assign near2     = sd[ST_OUT].n2;
  assign sfac      = sd[ST_OUT].sf;
  assign tfac      = sd[ST_OUT].tf;

  // Wide products of the dots
  cpsc_wmul u_mul_ae (.clk, .en(adv), .x(sd[0].dots.a), .y(sd[0].dots.e), .p(ae));
  cpsc_wmul u_mul_bb (.clk, .en(adv), .x(sd[0].dots.b), .y(sd[0].dots.b), .p(bb));
  cpsc_wmul u_mul_bf (.clk, .en(adv), .x(sd[0].dots.b), .y(sd[0].dots.f), .p(bf));
  cpsc_wmul u_mul_ce (.clk, .en(adv), .x(sd[0].dots.c), .y(sd[0].dots.e), .p(ce));

  // First factor from the unclamped solution
  cpsc_div u_div_s1 (
    .clk, .en(adv), .num(sd[ST_PAR].num1), .den(sd[ST_PAR].det), .q(q1)
  );

  // Recomputed first factor and second factor
  cpsc_div u_div_s2 (
    .clk, .en(adv), .num(sd[ST_SEL].snum),
    .den(WIDE_W'($signed(sd[ST_SEL].dots.a))), .q(q2)
  );
  cpsc_div u_div_t (
    .clk, .en(adv), .num(sd[ST_SEL].tnum), .den(sd[ST_SEL].tden), .q(q3)
  );

  // Next value of each stage
  always_comb begin
    logic [CMP_W-1:0]        lhs;
    logic [FAC_W-1:0]        s1v;
    logic [DOT_W-1:0]        bm;
    logic [WIDE_W-1:0]       pw;
    logic                    neg;
    logic                    gt;
    logic signed [PIP_W-1:0] rt;

    nx[0]      = '0;
    nx[0].geo  = pop_item.geo;
    nx[0].dots = pop_item.dots;
    for (int k = 1; k < NST; k++) begin
      nx[k] = sd[k-1];
    end

    // Determinant, numerator and tolerance limb products
    nx[ST_DET].det  = ae - bb;
    nx[ST_DET].num1 = bf - ce;
    for (int j = 0; j < TPP_N; j++) begin
      nx[ST_DET].tpp[j] = tol * ae[LIMB_W*j +: LIMB_W];
    end

    // Sum the tolerance threshold
    nx[ST_RHS].rhs = '0;
    for (int j = 0; j < TPP_N; j++) begin
      nx[ST_RHS].rhs = nx[ST_RHS].rhs + (CMP_W'(sd[ST_RHS-1].tpp[j]) << (LIMB_W * j));
    end

    // Drop the unclamped solution for points, parallel or flat pairs
    lhs = CMP_W'(sd[ST_PAR-1].det) << TOL_W;
    nx[ST_PAR].force1 = sd[ST_PAR-1].dots.pt1 || sd[ST_PAR-1].dots.pt2
                      || sd[ST_PAR-1].det[WIDE_W-1] || (sd[ST_PAR-1].det == '0)
                      || (lhs < sd[ST_PAR-1].rhs);

    // Product b * s in limbs
    s1v = sd[ST_D1].force1 ? '0 : q1;
    bm  = sd[ST_D1].dots.b[DOT_W-1] ? DOT_W'(-sd[ST_D1].dots.b) : sd[ST_D1].dots.b;
    nx[ST_BPP].s1     = s1v;
    nx[ST_BPP].bsg    = sd[ST_D1].dots.b[DOT_W-1];
    nx[ST_BPP].bpp[0] = bm[LIMB_W-1:0] * s1v;
    nx[ST_BPP].bpp[1] = bm[DOT_W-1:LIMB_W] * s1v;

    // Second factor numerator and denominator
    pw = WIDE_W'(sd[ST_BPP].bpp[0]) + (WIDE_W'(sd[ST_BPP].bpp[1]) << LIMB_W);
    nx[ST_TN].tnum = (sd[ST_BPP].bsg ? -pw : pw)
                   + (WIDE_W'($signed(sd[ST_BPP].dots.f)) << FAC_FRAC);
    nx[ST_TN].tden = WIDE_W'($signed(sd[ST_BPP].dots.e)) << FAC_FRAC;

    // Pick how each factor is finished
    neg = sd[ST_TN].tnum[WIDE_W-1];
    gt  = ($signed(sd[ST_TN].tnum) > $signed(sd[ST_TN].tden));
    nx[ST_SEL].snum  = -WIDE_W'($signed(sd[ST_TN].dots.c));
    nx[ST_SEL].tzero = 1'b0;
    nx[ST_SEL].ssel  = SSEL_FIRST;
    if (sd[ST_TN].dots.pt1) begin
      nx[ST_SEL].ssel  = SSEL_ZERO;
      nx[ST_SEL].tzero = sd[ST_TN].dots.pt2;
    end else if (sd[ST_TN].dots.pt2) begin
      nx[ST_SEL].ssel  = SSEL_DIV;
      nx[ST_SEL].tzero = 1'b1;
    end else if (neg) begin
      nx[ST_SEL].ssel = SSEL_DIV;
    end else if (gt) begin
      nx[ST_SEL].ssel = SSEL_DIV;
      nx[ST_SEL].snum = WIDE_W'($signed(sd[ST_TN].dots.b))
                      - WIDE_W'($signed(sd[ST_TN].dots.c));
    end

    // Final factors and interpolation products
    case (sd[ST_D2].ssel)
      SSEL_ZERO:  nx[ST_IP].sf = '0;
      SSEL_FIRST: nx[ST_IP].sf = sd[ST_D2].s1;
      SSEL_DIV:   nx[ST_IP].sf = q2;
      default:    nx[ST_IP].sf = '0;
    endcase
    nx[ST_IP].tf = sd[ST_D2].tzero ? '0 : q3;
    for (int i = 0; i < 3; i++) begin
      nx[ST_IP].ip[i]     = $signed(sd[ST_D2].geo.d1[i]) * $signed({1'b0, nx[ST_IP].sf});
      nx[ST_IP].ip[3 + i] = $signed(sd[ST_D2].geo.d2[i]) * $signed({1'b0, nx[ST_IP].tf});
    end

    // Round and add to the start points
    for (int i = 0; i < 3; i++) begin
      rt = $signed(sd[ST_IP].ip[i]) + PIP_W'(1 << (FAC_FRAC - 1));
      nx[ST_OUT].n1[i] = sd[ST_IP].geo.p1[i] + CRD_W'(rt >>> FAC_FRAC);
      rt = $signed(sd[ST_IP].ip[3 + i]) + PIP_W'(1 << (FAC_FRAC - 1));
      nx[ST_OUT].n2[i] = sd[ST_IP].geo.p2[i] + CRD_W'(rt >>> FAC_FRAC);
    end
  end

  // Hold stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NST-2:0], q_valid};
    end
  end

  // Advance stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NST; k++) begin
        sd[k] <= nx[k];
      end
    end
  end

endmodule

// File: hdl/closest_points_between_segments_core.sv
// Channel   Signals                        Direction  Accepted when
// input     in_valid/in_ready + 12 coords  in         in_valid && in_ready
// result    out_valid/out_ready + 8 fields out        out_valid && out_ready
// config    cfg_we/cfg_wdata               in         cfg_we high
//
// One item a cycle sustained while the output is not stalled. Items pass
// the front dot-product pipe, the queue and then the solver pipe, which holds
// three 19-stage restoring dividers (one quotient bit a stage).
// Reset is synchronous: it clears valid bits and queue pointers and loads the tolerance reset value.
// An output stall freezes the solver pipe; the front keeps taking items until
// the four-entry queue is full and the front's own last stage holds an item.
`include "closest_points_between_segments_core_macros.svh"

module closest_points_between_segments_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [31:0]                   first_start_x,
  input  logic [31:0]                   first_start_y,
  input  logic [31:0]                   first_start_z,
  input  logic [31:0]                   first_end_x,
  input  logic [31:0]                   first_end_y,
  input  logic [31:0]                   first_end_z,
  input  logic [31:0]                   second_start_x,
  input  logic [31:0]                   second_start_y,
  input  logic [31:0]                   second_start_z,
  input  logic [31:0]                   second_end_x,
  input  logic [31:0]                   second_end_y,
  input  logic [31:0]                   second_end_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [31:0]                   near_first_x,
  output logic [31:0]                   near_first_y,
  output logic [31:0]                   near_first_z,
  output logic [31:0]                   near_second_x,
  output logic [31:0]                   near_second_y,
  output logic [31:0]                   near_second_z,
  output logic [cpsc_pkg::FAC_W-1:0]    first_factor,
  output logic [cpsc_pkg::FAC_W-1:0]    second_factor,
  input  logic                          cfg_we,
  input  logic [cpsc_pkg::TOL_W-1:0]    cfg_wdata
);
  import cpsc_pkg::*;

  logic [TOL_W-1:0]       tol;
  logic [11:0][CRD_W-1:0] raw_in;
  logic                   push;
  logic                   q_ready;
  logic                   q_valid;
  logic                   pop;
  fe_t                    push_item;
  fe_t                    pop_item;
  fifo_stat_t             fstat;
  vec_crd_t               near1;
  vec_crd_t               near2;

  // Hold the parallel tolerance
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (cfg_we) begin
      tol <= cfg_wdata;
    end
  end

  assign raw_in = {second_end_z, second_end_y, second_end_x,
                   second_start_z, second_start_y, second_start_x,
                   first_end_z, first_end_y, first_end_x,
                   first_start_z, first_start_y, first_start_x};

  cpsc_front u_front (
    .clk, .rst, .in_valid, .in_ready, .raw_in,
    .push, .q_ready, .push_item
  );

  cpsc_fifo u_fifo (
    .clk, .rst, .push, .push_item, .q_ready,
    .pop, .q_valid, .pop_item, .stat(fstat)
  );

  cpsc_back u_back (
    .clk, .rst, .tol, .q_valid, .pop, .pop_item,
    .out_valid, .out_ready, .near1, .near2,
    .sfac(first_factor), .tfac(second_factor)
  );

  assign near_first_x  = near1[0];
  assign near_first_y  = near1[1];
  assign near_first_z  = near1[2];
  assign near_second_x = near2[0];
  assign near_second_y = near2[1];
  assign near_second_z = near2[2];

  `CPSC_ASSERT(a_fac_range, clk, rst, !out_valid || (first_factor <= FAC_ONE && second_factor <= FAC_ONE))
  `CPSC_ASSERT(a_fifo_stat, clk, rst, !(fstat.full && fstat.empty))
  `CPSC_ASSERT(a_no_overflow, clk, rst, !(push && fstat.full))
  `CPSC_ASSERT_NEXT(a_pop_drain, clk, rst, fstat.full && pop && !push, !fstat.full)

endmodule
